>>> rtl/cvg_pkg.sv
// ----------------------------------------------------------------------------
// cvg_pkg: shared types and constants of the chord voicing generator
// Voltage format, inversion and voicing codes, note bundles and the output
// saturation helper.
// ----------------------------------------------------------------------------
package cvg_pkg;

  localparam int KnobW   = 13;
  localparam int VoltW   = 16;
  localparam int CfgIdxW = 2;

  localparam logic [KnobW-1:0] OffsetKnobRst    = 13'd2048;
  localparam logic [KnobW-1:0] InversionKnobRst = 13'd0;
  localparam logic [KnobW-1:0] VoicingKnobRst   = 13'd0;

  localparam logic signed [16:0] OctaveUnits = 17'sd3072;
  localparam logic signed [16:0] OutLimit    = 17'sd24576;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_OFFSET_KNOB    = 2'd0,
    CFG_INVERSION_KNOB = 2'd1,
    CFG_VOICING_KNOB   = 2'd2
  } cfg_idx_e;

  // inversion after clamping to -1..2
  typedef enum logic [1:0] {
    INV_DOWN   = 2'd0,   // -1: root-or-second leads
    INV_ROOT   = 2'd1,   //  0
    INV_FIRST  = 2'd2,   //  1
    INV_SECOND = 2'd3    //  2
  } inv_e;

  // voicing after clamping to -2..2
  typedef enum logic [2:0] {
    VOC_NONE        = 3'd0,  // -2: voices untouched
    VOC_DROP_TWO    = 3'd1,  // -1
    VOC_DROP_THREE  = 3'd2,  //  0
    VOC_DROP_2_4    = 3'd3,  //  1
    VOC_RAISE_2_4   = 3'd4   //  2
  } voc_e;

  typedef logic signed [VoltW-1:0] volt_t;

  typedef struct packed {
    volt_t root;
    volt_t second;
    volt_t third;
    volt_t fifth;
    volt_t seventh;
  } notes_t;

  typedef struct packed {
    volt_t root;
    volt_t third;
    volt_t fifth;
    volt_t seventh;
    volt_t voice_one;
    volt_t voice_two;
    volt_t voice_three;
    volt_t voice_four;
  } chord_out_t;

  // clip to +-8 V
  function automatic volt_t sat_volt(logic signed [16:0] v);
    volt_t r;
    if (v > OutLimit) begin
      r = OutLimit[VoltW-1:0];
    end else if (v < -OutLimit) begin
      r = VoltW'(-OutLimit);
    end else begin
      r = v[VoltW-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/cvg_voicer.sv
// ----------------------------------------------------------------------------
// cvg_voicer: inversion, voicing and output saturation
// Arranges the chord tones into four voices, shifts voices by octaves and
// clips every output to +-8 V.
// ----------------------------------------------------------------------------
module cvg_voicer (
  input  cvg_pkg::notes_t     notes_i,
  input  cvg_pkg::inv_e       inv_i,
  input  cvg_pkg::voc_e       voc_i,
  output cvg_pkg::chord_out_t chord_o
);

  logic signed [16:0] root_x, second_x, third_x, fifth_x, seventh_x;
  logic signed [16:0] v1, v2, v3, v4;

  assign root_x    = $signed({notes_i.root[15], notes_i.root});
  assign second_x  = $signed({notes_i.second[15], notes_i.second});
  assign third_x   = $signed({notes_i.third[15], notes_i.third});
  assign fifth_x   = $signed({notes_i.fifth[15], notes_i.fifth});
  assign seventh_x = $signed({notes_i.seventh[15], notes_i.seventh});

  always_comb begin
    unique case (inv_i)
      cvg_pkg::INV_DOWN: begin
        v1 = second_x; v2 = third_x; v3 = fifth_x; v4 = seventh_x;
      end
      cvg_pkg::INV_ROOT: begin
        v1 = third_x; v2 = fifth_x; v3 = seventh_x;
        v4 = second_x + cvg_pkg::OctaveUnits;
      end
      cvg_pkg::INV_FIRST: begin
        v1 = fifth_x; v2 = seventh_x;
        v3 = second_x + cvg_pkg::OctaveUnits;
        v4 = third_x + cvg_pkg::OctaveUnits;
      end
      default: begin
        v1 = seventh_x;
        v2 = second_x + cvg_pkg::OctaveUnits;
        v3 = third_x + cvg_pkg::OctaveUnits;
        v4 = fifth_x + cvg_pkg::OctaveUnits;
      end
    endcase

    unique case (voc_i)
      cvg_pkg::VOC_DROP_TWO: begin
        v2 = v2 - cvg_pkg::OctaveUnits;
      end
      cvg_pkg::VOC_DROP_THREE: begin
        v3 = v3 - cvg_pkg::OctaveUnits;
      end
      cvg_pkg::VOC_DROP_2_4: begin
        v2 = v2 - cvg_pkg::OctaveUnits;
        v4 = v4 - cvg_pkg::OctaveUnits;
      end
      cvg_pkg::VOC_RAISE_2_4: begin
        v2 = v2 + cvg_pkg::OctaveUnits;
        v4 = v4 + cvg_pkg::OctaveUnits;
      end
      default: begin
      end
    endcase

    chord_o.root        = cvg_pkg::sat_volt(root_x);
    chord_o.third       = cvg_pkg::sat_volt(third_x);
    chord_o.fifth       = cvg_pkg::sat_volt(fifth_x);
    chord_o.seventh     = cvg_pkg::sat_volt(seventh_x);
    chord_o.voice_one   = cvg_pkg::sat_volt(v1);
    chord_o.voice_two   = cvg_pkg::sat_volt(v2);
    chord_o.voice_three = cvg_pkg::sat_volt(v3);
    chord_o.voice_four  = cvg_pkg::sat_volt(v4);
  end

endmodule

>>> rtl/chord_voicing_generator.sv
// ----------------------------------------------------------------------------
// chord_voicing_generator: four-note chord and voicing from a pitch CV
// Four-stage pipeline turning a 1 V/octave pitch, three CVs and eleven
// alteration gates into four chord tones and four voiced outputs.
// ----------------------------------------------------------------------------
// Takes one request per clock while the output is not stalled. The request
// passes four pipeline registers (numerators, rounded quotients, chord
// tones, output register), the first loaded at the accepting edge, each
// with its own valid bit. A stall on the output backs up stage by stage, so
// empty stages keep filling and the input is only stalled once every stage
// holds a request. Voltages are 3072 units per volt. The knob registers are
// written through cfg_we_i/cfg_index_i/cfg_data_i (index 0 transpose,
// 1 inversion, 2 voicing; index 3 is ignored) and should only be changed
// while the pipeline is empty.
// ----------------------------------------------------------------------------
module chord_voicing_generator (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  input  logic                        cfg_we_i,
  input  logic [cvg_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [cvg_pkg::KnobW-1:0]   cfg_data_i,

  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [15:0]          pitch_in_i,
  input  logic signed [15:0]          offset_cv_i,
  input  logic signed [15:0]          inversion_cv_i,
  input  logic signed [15:0]          voicing_cv_i,
  input  logic [10:0]                 chord_flags_i,

  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [15:0]          root_note_o,
  output logic signed [15:0]          third_note_o,
  output logic signed [15:0]          fifth_note_o,
  output logic signed [15:0]          seventh_note_o,
  output logic signed [15:0]          voice_one_o,
  output logic signed [15:0]          voice_two_o,
  output logic signed [15:0]          voice_three_o,
  output logic signed [15:0]          voice_four_o
);

  // magnitude plus half divisor, for rounding half away from zero
  function automatic logic [20:0] mag_half(logic signed [20:0] n, logic [20:0] half);
    logic [20:0] m;
    m = n[20] ? 21'(-n) : 21'(n);
    return m + half;
  endfunction

  // --------------------------------------------------------------------------
  // Knob registers
  // --------------------------------------------------------------------------
  logic [cvg_pkg::KnobW-1:0] offset_knob_q, inversion_knob_q, voicing_knob_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_knob_q    <= cvg_pkg::OffsetKnobRst;
      inversion_knob_q <= cvg_pkg::InversionKnobRst;
      voicing_knob_q   <= cvg_pkg::VoicingKnobRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cvg_pkg::CFG_OFFSET_KNOB:    offset_knob_q    <= cfg_data_i;
        cvg_pkg::CFG_INVERSION_KNOB: inversion_knob_q <= cfg_data_i;
        cvg_pkg::CFG_VOICING_KNOB:   voicing_knob_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control: a stage loads when it is empty or its successor loads
  // --------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic load1, load2, load3, load4;

  assign load4 = !out_valid_q || !out_stall_i;
  assign load3 = !s3_valid_q || load4;
  assign load2 = !s2_valid_q || load3;
  assign load1 = !s1_valid_q || load2;

  assign in_stall_o  = !load1;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load1) s1_valid_q  <= in_valid_i;
      if (load2) s2_valid_q  <= s1_valid_q;
      if (load3) s3_valid_q  <= s2_valid_q;
      if (load4) out_valid_q <= s3_valid_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: numerators, split into sign and magnitude plus half
  // --------------------------------------------------------------------------
  logic signed [20:0] n_pitch, n_semis, n_inv, n_voc;
  logic [20:0]        m_pitch, m_semis, m_inv, m_voc;

  always_comb begin
    n_pitch = $signed({{5{pitch_in_i[15]}}, pitch_in_i});
    n_semis = 21'sd27 * $signed({8'd0, offset_knob_q})
            + 21'sd2 * $signed({{5{offset_cv_i[15]}}, offset_cv_i})
            - 21'sd55296;
    n_inv   = 21'sd9 * $signed({8'd0, inversion_knob_q})
            + $signed({{5{inversion_cv_i[15]}}, inversion_cv_i})
            - 21'sd9216;
    n_voc   = 21'sd45 * $signed({8'd0, voicing_knob_q})
            + 21'sd4 * $signed({{5{voicing_cv_i[15]}}, voicing_cv_i})
            - 21'sd73728;
    m_pitch = mag_half(n_pitch, 21'd1536);
    m_semis = mag_half(n_semis, 21'd4608);
    m_inv   = mag_half(n_inv, 21'd4608);
    m_voc   = mag_half(n_voc, 21'd18432);
  end

  logic signed [15:0] s1_pitch_q;
  logic [10:0]        s1_flags_q;
  logic [15:0]        s1_pmag_q;
  logic [17:0]        s1_smag_q;
  logic [16:0]        s1_imag_q;
  logic [18:0]        s1_vmag_q;
  logic               s1_psign_q, s1_ssign_q, s1_isign_q, s1_vsign_q;

  always_ff @(posedge clk_i) begin
    if (load1) begin
      s1_pitch_q <= pitch_in_i;
      s1_flags_q <= chord_flags_i;
      s1_pmag_q  <= m_pitch[15:0];
      s1_smag_q  <= m_semis[17:0];
      s1_imag_q  <= m_inv[16:0];
      s1_vmag_q  <= m_voc[18:0];
      s1_psign_q <= n_pitch[20];
      s1_ssign_q <= n_semis[20];
      s1_isign_q <= n_inv[20];
      s1_vsign_q <= n_voc[20];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: quotients by reciprocal multiply, clamps, gate intervals
  //   /3072 -> >>10 then x*43>>7 ; /9216 and /36864 -> >>10 or >>12, x*57>>9
  // --------------------------------------------------------------------------
  logic [11:0]       p_oct;
  logic [13:0]       p_semis;
  logic [12:0]       p_inv, p_voc;
  logic [3:0]        q_oct, q_inv, q_voc;
  logic [4:0]        q_semis;
  logic signed [4:0] oct_d;
  logic signed [5:0] semis_d;
  cvg_pkg::inv_e     inv_d;
  cvg_pkg::voc_e     voc_d;
  logic [2:0]        third_d;
  logic [3:0]        fifth_d, seventh_d;
  logic [1:0]        second_d;

  always_comb begin
    p_oct   = 12'(s1_pmag_q[15:10]) * 12'd43;
    p_semis = 14'(s1_smag_q[17:10]) * 14'd57;
    p_inv   = 13'(s1_imag_q[16:10]) * 13'd57;
    p_voc   = 13'(s1_vmag_q[18:12]) * 13'd57;
    q_oct   = p_oct[10:7];
    q_semis = p_semis[13:9];
    q_inv   = p_inv[12:9];
    q_voc   = p_voc[12:9];

    oct_d   = s1_psign_q ? -$signed({1'b0, q_oct})   : $signed({1'b0, q_oct});
    semis_d = s1_ssign_q ? -$signed({1'b0, q_semis}) : $signed({1'b0, q_semis});

    // inversion clamp -1..2
    if (s1_isign_q) begin
      inv_d = (q_inv != 4'd0) ? cvg_pkg::INV_DOWN : cvg_pkg::INV_ROOT;
    end else if (q_inv == 4'd0) begin
      inv_d = cvg_pkg::INV_ROOT;
    end else if (q_inv == 4'd1) begin
      inv_d = cvg_pkg::INV_FIRST;
    end else begin
      inv_d = cvg_pkg::INV_SECOND;
    end

    // voicing clamp -2..2
    if (s1_vsign_q) begin
      if (q_voc == 4'd0)      voc_d = cvg_pkg::VOC_DROP_THREE;
      else if (q_voc == 4'd1) voc_d = cvg_pkg::VOC_DROP_TWO;
      else                    voc_d = cvg_pkg::VOC_NONE;
    end else begin
      if (q_voc == 4'd0)      voc_d = cvg_pkg::VOC_DROP_THREE;
      else if (q_voc == 4'd1) voc_d = cvg_pkg::VOC_DROP_2_4;
      else                    voc_d = cvg_pkg::VOC_RAISE_2_4;
    end

    // gates in bit order, later ones win
    third_d   = 3'd4;
    fifth_d   = 4'd7;
    seventh_d = 4'd11;
    second_d  = 2'd0;
    if (s1_flags_q[0])  third_d   = 3'd3;   // flat3
    if (s1_flags_q[1])  fifth_d   = 4'd6;   // flat5
    if (s1_flags_q[2])  fifth_d   = 4'd8;   // sharp5
    if (s1_flags_q[3])  seventh_d = 4'd10;  // flat7
    if (s1_flags_q[4])  second_d  = 2'd2;   // sus2
    if (s1_flags_q[5])  third_d   = 3'd5;   // sus4
    if (s1_flags_q[6])  fifth_d   = 4'd9;   // six5
    if (s1_flags_q[7])  seventh_d = 4'd9;   // six7
    if (s1_flags_q[8])  second_d  = 2'd1;   // flat9
    if (s1_flags_q[9])  second_d  = 2'd3;   // sharp9
    if (s1_flags_q[10]) seventh_d = 4'd12;  // one7
  end

  logic signed [15:0] s2_pitch_q;
  logic signed [4:0]  s2_oct_q;
  logic signed [5:0]  s2_semis_q;
  cvg_pkg::inv_e      s2_inv_q;
  cvg_pkg::voc_e      s2_voc_q;
  logic [2:0]         s2_third_q;
  logic [3:0]         s2_fifth_q, s2_seventh_q;
  logic [1:0]         s2_second_q;

  always_ff @(posedge clk_i) begin
    if (load2) begin
      s2_pitch_q   <= s1_pitch_q;
      s2_oct_q     <= oct_d;
      s2_semis_q   <= semis_d;
      s2_inv_q     <= inv_d;
      s2_voc_q     <= voc_d;
      s2_third_q   <= third_d;
      s2_fifth_q   <= fifth_d;
      s2_seventh_q <= seventh_d;
      s2_second_q  <= second_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: root folded into one octave, then the chord tones
  // --------------------------------------------------------------------------
  logic signed [16:0] root_x;
  cvg_pkg::notes_t    notes_d;

  always_comb begin
    root_x = $signed({s2_pitch_q[15], s2_pitch_q})
           - $signed({{12{s2_oct_q[4]}}, s2_oct_q}) * cvg_pkg::OctaveUnits
           + $signed({{11{s2_semis_q[5]}}, s2_semis_q}) * 17'sd256;
    // root stays well inside 16 bits after folding
    notes_d.root    = root_x[15:0];
    notes_d.second  = notes_d.root + $signed({6'd0, s2_second_q, 8'd0});
    notes_d.third   = notes_d.root + $signed({5'd0, s2_third_q, 8'd0});
    notes_d.fifth   = notes_d.root + $signed({4'd0, s2_fifth_q, 8'd0});
    notes_d.seventh = notes_d.root + $signed({4'd0, s2_seventh_q, 8'd0});
  end

  cvg_pkg::notes_t s3_notes_q;
  cvg_pkg::inv_e   s3_inv_q;
  cvg_pkg::voc_e   s3_voc_q;

  always_ff @(posedge clk_i) begin
    if (load3) begin
      s3_notes_q <= notes_d;
      s3_inv_q   <= s2_inv_q;
      s3_voc_q   <= s2_voc_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: voicing and saturation into the output register
  // --------------------------------------------------------------------------
  cvg_pkg::chord_out_t chord_d, chord_q;

  cvg_voicer u_voicer (
    .notes_i (s3_notes_q),
    .inv_i   (s3_inv_q),
    .voc_i   (s3_voc_q),
    .chord_o (chord_d)
  );

  always_ff @(posedge clk_i) begin
    if (load4) begin
      chord_q <= chord_d;
    end
  end

  assign root_note_o    = chord_q.root;
  assign third_note_o   = chord_q.third;
  assign fifth_note_o   = chord_q.fifth;
  assign seventh_note_o = chord_q.seventh;
  assign voice_one_o    = chord_q.voice_one;
  assign voice_two_o    = chord_q.voice_two;
  assign voice_three_o  = chord_q.voice_three;
  assign voice_four_o   = chord_q.voice_four;

endmodule
